// ----- rtl/pwc_pkg.sv -----
`timescale 1ns / 1ps

package pwc_pkg;

    localparam int TS_W    = 16;
    localparam int VALUE_W = 17;
    localparam int CH_W    = 3;
    localparam int KIND_W  = 2;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    // Item kinds. The fourth code carries no meaning and is dropped.
    localparam logic [KIND_W-1:0] KIND_CAPTURE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LEVEL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

    // Read status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_WARN = 1'b1;

    // Register map.
    localparam logic [PADDR_W-1:0] ADDR_COUNTER_TOP = 2'd0;

    localparam logic [TS_W-1:0] COUNTER_TOP_RESET = 16'hFFFF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CH_W-1:0]   channel;
        logic [TS_W-1:0]   capture_value;
        logic              level;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               status;
        logic               error_flag;
    } t_out_item;

    // Command from the request stage to the capture channel bank.
    typedef struct packed {
        logic            evt;
        logic            rd;
        logic [CH_W-1:0] channel;
    } t_cap_cmd;

endpackage

// ----- rtl/pwc_capture_bank.sv -----
`timescale 1ns / 1ps

module pwc_capture_bank import pwc_pkg::*; #(
    parameter int CAPTURE_CHANNELS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cap_cmd           i_cmd,
    input  logic [TS_W-1:0]    i_capture_value,
    input  logic [TS_W-1:0]    i_counter_top,
    output logic               o_is_capture,
    output logic [VALUE_W-1:0] o_width
);

    localparam logic [CH_W:0] CapLast = (CH_W + 1)'(CAPTURE_CHANNELS);

    logic [CAPTURE_CHANNELS-1:0] r_expect_rising;
    logic [CAPTURE_CHANNELS-1:0] r_updated;
    logic [TS_W-1:0]             r_rise [CAPTURE_CHANNELS];
    logic [TS_W-1:0]             r_fall [CAPTURE_CHANNELS];

    logic [CH_W:0]               ch_ext;
    logic [CAPTURE_CHANNELS-1:0] hit;
    logic [TS_W-1:0]             sel_rise;
    logic [TS_W-1:0]             sel_fall;
    logic                        sel_updated;
    logic [VALUE_W-1:0]          wrap_width;

    assign ch_ext       = {1'b0, i_cmd.channel};
    assign o_is_capture = (ch_ext >= (CH_W + 1)'(1)) && (ch_ext <= CapLast);

    always_comb begin
        hit         = '0;
        sel_rise    = '0;
        sel_fall    = '0;
        sel_updated = 1'b0;
        for (int c = 0; c < CAPTURE_CHANNELS; c++) begin
            hit[c] = (ch_ext == (CH_W + 1)'(c + 1));
            if (hit[c]) begin
                sel_rise    = r_rise[c];
                sel_fall    = r_fall[c];
                sel_updated = r_updated[c];
            end
        end
    end

    // A pulse that crosses the counter wrap spans top + 1 - rise + fall.
    assign wrap_width = VALUE_W'(({1'b0, i_counter_top} + VALUE_W'(1))
                                 - {1'b0, sel_rise} + {1'b0, sel_fall});

    always_comb begin
        if (!sel_updated) begin
            o_width = '0;
        end else if (sel_fall > sel_rise) begin
            o_width = {1'b0, sel_fall - sel_rise};
        end else begin
            o_width = wrap_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_rising <= '1;
            r_updated       <= '0;
            for (int c = 0; c < CAPTURE_CHANNELS; c++) begin
                r_rise[c] <= '0;
                r_fall[c] <= '0;
            end
        end else begin
            for (int c = 0; c < CAPTURE_CHANNELS; c++) begin
                if (hit[c] && i_cmd.evt) begin
                    if (r_expect_rising[c]) begin
                        r_rise[c]          <= i_capture_value;
                        r_expect_rising[c] <= 1'b0;
                        r_updated[c]       <= 1'b0;
                    end else begin
                        r_fall[c]          <= i_capture_value;
                        r_expect_rising[c] <= 1'b1;
                        r_updated[c]       <= 1'b1;
                    end
                end else if (hit[c] && i_cmd.rd) begin
                    r_updated[c] <= 1'b0;
                end
            end
        end
    end

endmodule

// ----- rtl/multi_channel_pulse_width_capture.sv -----
`timescale 1ns / 1ps
// A read request passes from the request register through the result register to o_out.
// Throughput: one request per cycle unless a read stalls; capture and level events produce no result.
// A read stalls in the request register only while the result register is full and not taken.
// Reset (i_rst_n low at a clock edge) clears all channel state, the error flag, both
// valid bits, and sets counter_top to 65535. No clearing pass is needed.

module multi_channel_pulse_width_capture import pwc_pkg::*; #(
    parameter int CAPTURE_CHANNELS = 4,
    parameter int LEVEL_CHANNELS   = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    // Request channel.
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in,

    // Result channel.
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out,

    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Storage for level channels keeps one entry even when there are none, so that
    // the vector never collapses to zero width. Channel numbers are compared with
    // one extra bit so that the top of the capture range can reach eight.
    localparam int            LvlDepth = (LEVEL_CHANNELS > 0) ? LEVEL_CHANNELS : 1;
    localparam logic [CH_W:0] CapLast  = (CH_W + 1)'(CAPTURE_CHANNELS);
    localparam logic [CH_W:0] LvlLast  = (CH_W + 1)'(CAPTURE_CHANNELS + LEVEL_CHANNELS);

    // Request register: the first stage. It takes a new request whenever it is empty
    // or its current request completes in this cycle.
    logic     r_in_valid;
    t_in_item r_in;

    // Result register: the second stage, held until the consumer takes it.
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic [TS_W-1:0]     r_counter_top;
    logic [LvlDepth-1:0] r_level;
    logic                r_event_error;

    logic               is_cap_evt;
    logic               is_lvl_evt;
    logic               is_read;
    logic               out_free;
    logic               fire;
    logic [CH_W:0]      ch_ext;
    logic               is_level_ch;
    logic               lvl_sel;
    logic               cap_hit;
    logic [VALUE_W-1:0] cap_width;
    logic               cfg_write;
    t_cap_cmd           cap_cmd;

    // Request decode.
    always_comb begin
        is_cap_evt = 1'b0;
        is_lvl_evt = 1'b0;
        is_read    = 1'b0;
        unique case (r_in.kind)
            KIND_CAPTURE: is_cap_evt = 1'b1;
            KIND_LEVEL:   is_lvl_evt = 1'b1;
            KIND_READ:    is_read    = 1'b1;
            default:      ;
        endcase
    end

    // Events always complete at once; a read completes when the result register is
    // free or is being emptied in this same cycle.
    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && (!is_read || out_free);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Capture channels: edge timestamps, the edge phase and the updated mark live in
    // the bank, which also forms the pulse width for the addressed channel.
    assign cap_cmd.evt     = fire && is_cap_evt;
    assign cap_cmd.rd      = fire && is_read;
    assign cap_cmd.channel = r_in.channel;

    pwc_capture_bank #(
        .CAPTURE_CHANNELS (CAPTURE_CHANNELS)
    ) u_capture_bank (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cap_cmd),
        .i_capture_value (r_in.capture_value),
        .i_counter_top   (r_counter_top),
        .o_is_capture    (cap_hit),
        .o_width         (cap_width)
    );

    // Level channels follow directly after the capture channels.
    assign ch_ext      = {1'b0, r_in.channel};
    assign is_level_ch = (ch_ext > CapLast) && (ch_ext <= LvlLast);

    always_comb begin
        lvl_sel = 1'b0;
        for (int l = 0; l < LEVEL_CHANNELS; l++) begin
            if (ch_ext == (CH_W + 1)'(CAPTURE_CHANNELS + 1 + l)) begin
                lvl_sel = r_level[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (fire && is_lvl_evt) begin
            for (int l = 0; l < LEVEL_CHANNELS; l++) begin
                if (ch_ext == (CH_W + 1)'(CAPTURE_CHANNELS + 1 + l)) begin
                    r_level[l] <= r_in.level;
                end
            end
        end
    end

    // The error flag is sticky: any capture event outside the capture range or level
    // event outside the level range sets it, and only reset clears it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_error <= 1'b0;
        end else if (fire && ((is_cap_evt && !cap_hit) || (is_lvl_evt && !is_level_ch))) begin
            r_event_error <= 1'b1;
        end
    end

    // Read result. An unknown channel reads as zero with the warning status set.
    always_comb begin
        n_out.value      = '0;
        n_out.status     = STATUS_OK;
        n_out.error_flag = r_event_error;
        if (cap_hit) begin
            n_out.value = cap_width;
        end else if (is_level_ch) begin
            n_out.value = {{(VALUE_W - 1){1'b0}}, lvl_sel};
        end else begin
            n_out.status = STATUS_WARN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && is_read) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && is_read) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Configuration register. Only the low 16 bits of the write data are kept.
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_COUNTER_TOP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter_top <= COUNTER_TOP_RESET;
        end else if (cfg_write) begin
            r_counter_top <= pwdata[TS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_COUNTER_TOP) ? {{(PDATA_W - TS_W){1'b0}}, r_counter_top}
                                                : '0;

endmodule

// ----- rtl/pwc_checker.sv -----
`timescale 1ns / 1ps

module pwc_checker import pwc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input t_out_item          o_out,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata,
    input logic               pready
);

    // Remembers that a delivered result has already shown the error flag.
    logic r_seen_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_error <= 1'b0;
        end else if (o_out_valid && i_out_ready && o_out.error_flag) begin
            r_seen_error <= 1'b1;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    a_warning_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status |-> o_out.value == '0)
        else $error("warning result carries a nonzero value");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_error |-> o_out.error_flag)
        else $error("error flag dropped without reset");

    a_top_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && paddr == ADDR_COUNTER_TOP
        |=> paddr != ADDR_COUNTER_TOP
            || prdata == {{(PDATA_W - TS_W){1'b0}}, $past(pwdata[TS_W-1:0])})
        else $error("counter top readback mismatch");

endmodule

bind multi_channel_pulse_width_capture pwc_checker u_pwc_checker (.*);
